@@ rtl/core/rrhb_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and the legacy rate table for the radiotap rx header builder
// no dependencies

package rrhb_pkg;

   localparam int HDR_IDX_W = 6;

   localparam logic [5:0] HDR_LEN_LEGACY = 6'd23;
   localparam logic [5:0] HDR_LEN_HT     = 6'd26;
   localparam logic [5:0] HDR_LEN_VHT    = 6'd36;

   localparam logic [1:0] KIND_LEGACY = 2'd0;
   localparam logic [1:0] KIND_HT     = 2'd1;
   localparam logic [1:0] KIND_VHT    = 2'd2;

   localparam logic [7:0] CODE_HT_BASE  = 8'h80;
   localparam logic [7:0] CODE_VHT_BASE = 8'hA0;

   localparam logic [15:0] FREQ_5G_MIN = 16'd5000;

   localparam logic [15:0] CHAN_CCK  = 16'h0020;
   localparam logic [15:0] CHAN_OFDM = 16'h0040;
   localparam logic [15:0] CHAN_2GHZ = 16'h0080;
   localparam logic [15:0] CHAN_5GHZ = 16'h0100;

   localparam logic [7:0] FLAG_WEP      = 8'h04;
   localparam logic [7:0] PRESENT_BASE  = 8'h2B;
   localparam logic [7:0] PRESENT_RATE  = 8'h04;
   localparam logic [7:0] PRESENT_MCS   = 8'h08;
   localparam logic [7:0] PRESENT_VHT   = 8'h20;
   localparam logic [7:0] MCS_KNOWN     = 8'h03;
   localparam logic [7:0] VHT_KNOWN_BW  = 8'h40;
   localparam logic [7:0] VHT_BW_80     = 8'd4;
   localparam logic [7:0] VHT_BW_160    = 8'd11;
   localparam logic [3:0] VHT_MCS_MAX   = 4'd9;

   typedef struct packed {
      logic [7:0]        phy_rate;
      logic [63:0]       tsf_value;
      logic [15:0]       channel_mhz;
      logic signed [7:0] signal_dbm;
      logic              was_decrypted;
   } req_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       last_byte;
   } rsp_type;

   // everything the serializer needs to lay out one header
   typedef struct packed {
      logic [63:0] tsf;
      logic [15:0] freq;
      logic [15:0] chflags;
      logic [7:0]  sig;
      logic [7:0]  flags;
      logic [7:0]  rate;
      logic [7:0]  present0;
      logic [7:0]  present2;
      logic [5:0]  len;
      logic [7:0]  b23;
      logic [7:0]  b24;
      logic [7:0]  b25;
      logic [7:0]  b27;
      logic [7:0]  b28;
   } frame_type;

   // legacy rate in 500 kbps units, zero for a code not in the table
   function automatic logic [7:0] legacy_rate(input logic [7:0] code);
      logic [7:0] r;
      unique case (code)
         8'h1B:   r = 8'd2;
         8'h1A:   r = 8'd4;
         8'h19:   r = 8'd11;
         8'h18:   r = 8'd22;
         8'h0B:   r = 8'd12;
         8'h0F:   r = 8'd18;
         8'h0A:   r = 8'd24;
         8'h0E:   r = 8'd36;
         8'h09:   r = 8'd48;
         8'h0D:   r = 8'd72;
         8'h08:   r = 8'd96;
         8'h0C:   r = 8'd108;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/rrhb_decode.sv @@
`timescale 1ns / 1ps
// decode stage: turns one frame's metadata into a registered header layout
// depends on rrhb_pkg

module rrhb_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rrhb_pkg::req_type   in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rrhb_pkg::frame_type out_data
);

   logic                valid_ff, valid_in;
   rrhb_pkg::frame_type frame_ff, frame_in;

   logic [1:0] kind;
   logic [7:0] rate;
   logic       cck;
   logic [3:0] vht_mcs;
   logic [3:0] vht_nss;

   always_comb begin
      priority if (in_data.phy_rate < rrhb_pkg::CODE_HT_BASE) begin
         kind = rrhb_pkg::KIND_LEGACY;
      end else if (in_data.phy_rate < rrhb_pkg::CODE_VHT_BASE) begin
         kind = rrhb_pkg::KIND_HT;
      end else begin
         kind = rrhb_pkg::KIND_VHT;
      end
   end

   assign rate = (kind == rrhb_pkg::KIND_LEGACY) ?
                 rrhb_pkg::legacy_rate(in_data.phy_rate) : 8'd0;
   // the four cck codes sit at 0x18..0x1b
   assign cck  = (in_data.phy_rate[7:2] == 6'b000110);
   assign vht_mcs = (in_data.phy_rate[3:0] > rrhb_pkg::VHT_MCS_MAX) ?
                    rrhb_pkg::VHT_MCS_MAX : in_data.phy_rate[3:0];
   assign vht_nss = in_data.phy_rate[4] ? 4'd2 : 4'd1;

   always_comb begin
      frame_in          = '0;
      frame_in.tsf      = in_data.tsf_value;
      frame_in.freq     = in_data.channel_mhz;
      frame_in.sig      = in_data.signal_dbm;
      frame_in.flags    = in_data.was_decrypted ? rrhb_pkg::FLAG_WEP : 8'd0;
      frame_in.rate     = rate;
      frame_in.present0 = rrhb_pkg::PRESENT_BASE |
                          ((rate != 8'd0) ? rrhb_pkg::PRESENT_RATE : 8'd0);
      frame_in.chflags  = (in_data.channel_mhz >= rrhb_pkg::FREQ_5G_MIN) ?
                          rrhb_pkg::CHAN_5GHZ : rrhb_pkg::CHAN_2GHZ;
      unique case (kind)
         rrhb_pkg::KIND_LEGACY: begin
            frame_in.len     = rrhb_pkg::HDR_LEN_LEGACY;
            frame_in.chflags = frame_in.chflags |
                               ((cck && rate != 8'd0) ? rrhb_pkg::CHAN_CCK
                                                      : rrhb_pkg::CHAN_OFDM);
         end
         rrhb_pkg::KIND_HT: begin
            frame_in.len      = rrhb_pkg::HDR_LEN_HT;
            frame_in.present2 = rrhb_pkg::PRESENT_MCS;
            frame_in.b23      = rrhb_pkg::MCS_KNOWN;
            frame_in.b24      = {7'd0, in_data.phy_rate[4]};
            frame_in.b25      = {4'd0, in_data.phy_rate[3:0]};
         end
         rrhb_pkg::KIND_VHT: begin
            // byte 23 is alignment padding before the vht field
            frame_in.len      = rrhb_pkg::HDR_LEN_VHT;
            frame_in.present2 = rrhb_pkg::PRESENT_VHT;
            frame_in.b24      = rrhb_pkg::VHT_KNOWN_BW;
            frame_in.b27      = (in_data.phy_rate[7:5] == 3'b110) ?
                                rrhb_pkg::VHT_BW_160 : rrhb_pkg::VHT_BW_80;
            frame_in.b28      = {vht_mcs, vht_nss};
         end
         default: begin
            frame_in.len = rrhb_pkg::HDR_LEN_LEGACY;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         frame_ff <= frame_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = frame_ff;

endmodule

@@ rtl/core/rrhb_serializer.sv @@
`timescale 1ns / 1ps
// serializer: holds one header layout and walks it out one word per cycle while out_ready is high
// depends on rrhb_pkg

module rrhb_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rrhb_pkg::frame_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rrhb_pkg::rsp_type   out_data
);

   logic                                 valid_ff, valid_in;
   logic [rrhb_pkg::HDR_IDX_W-1:0]       idx_ff, idx_in;
   rrhb_pkg::frame_type                  frame_ff;
   logic                                 last;
   logic                                 load;
   logic [7:0]                           hbyte;

   assign last     = (idx_ff == frame_ff.len - 6'd1);
   assign in_ready = !valid_ff || (out_ready && last);
   assign load     = in_ready && in_valid;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (valid_ff && out_ready) begin
         idx_in = last ? '0 : idx_ff + 6'd1;
      end
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= in_data;
      end
   end

   // byte 17 is the rate or, when absent, padding before channel
   always_comb begin
      unique case (idx_ff)
         6'd2:    hbyte = {2'd0, frame_ff.len};
         6'd4:    hbyte = frame_ff.present0;
         6'd6:    hbyte = frame_ff.present2;
         6'd8:    hbyte = frame_ff.tsf[7:0];
         6'd9:    hbyte = frame_ff.tsf[15:8];
         6'd10:   hbyte = frame_ff.tsf[23:16];
         6'd11:   hbyte = frame_ff.tsf[31:24];
         6'd12:   hbyte = frame_ff.tsf[39:32];
         6'd13:   hbyte = frame_ff.tsf[47:40];
         6'd14:   hbyte = frame_ff.tsf[55:48];
         6'd15:   hbyte = frame_ff.tsf[63:56];
         6'd16:   hbyte = frame_ff.flags;
         6'd17:   hbyte = frame_ff.rate;
         6'd18:   hbyte = frame_ff.freq[7:0];
         6'd19:   hbyte = frame_ff.freq[15:8];
         6'd20:   hbyte = frame_ff.chflags[7:0];
         6'd21:   hbyte = frame_ff.chflags[15:8];
         6'd22:   hbyte = frame_ff.sig;
         6'd23:   hbyte = frame_ff.b23;
         6'd24:   hbyte = frame_ff.b24;
         6'd25:   hbyte = frame_ff.b25;
         6'd27:   hbyte = frame_ff.b27;
         6'd28:   hbyte = frame_ff.b28;
         default: hbyte = 8'd0;
      endcase
   end

   assign out_valid            = valid_ff;
   assign out_data.header_byte = hbyte;
   assign out_data.last_byte   = last;

endmodule

@@ rtl/core/radiotap_rx_header_builder_unit.sv @@
`timescale 1ns / 1ps
// Radiotap receive header builder: one frame's metadata in, its little-endian
// radiotap header out one byte per word, last byte marked. Headers are 23
// bytes for legacy codes, 26 for HT and 36 for VHT, sent over the one-byte-wide
// result channel. A frame enters a decode register and is laid out in a single
// pass; the next frame is accepted into that register while the current header
// drains, and a frame waiting there is loaded in the same cycle as the previous
// header's last byte is taken on the result channel. Depends on rrhb_pkg,
// rrhb_decode and rrhb_serializer.

module radiotap_rx_header_builder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrhb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrhb_pkg::rsp_type rsp_data
);

   logic                frame_valid;
   logic                frame_ready;
   rrhb_pkg::frame_type frame_data;

   rrhb_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (frame_valid),
      .out_ready (frame_ready),
      .out_data  (frame_data)
   );

   rrhb_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frame_valid),
      .in_ready  (frame_ready),
      .in_data   (frame_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
